>>> rtl/core/skt_pkg.sv
// Shared types and codes for the sorted key table.
package skt_pkg;

    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 27;
    localparam int GRADE_W  = 7;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LIST   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [GRADE_W-1:0] grade;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [KEY_W-1:0]    key;
        logic [GRADE_W-1:0]  grade;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_RD,
        ST_PROBE,
        ST_DECIDE,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_FIN,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_LIST_RD,
        ST_LIST_LD,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/core/skt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module skt_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/skt_seq.sv
// Sequencer: binary search, shift loops and list walk over the entry RAM.
module skt_seq #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [skt_pkg::FUNC_W-1:0]    func,
    input  logic [skt_pkg::KEY_W-1:0]     key,
    input  logic [skt_pkg::GRADE_W-1:0]   grade,
    output logic                          res_valid,
    output skt_pkg::result_t              res,
    input  logic                          res_ready,
    output logic                          ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]      ram_wr_addr,
    output skt_pkg::entry_t               ram_wr_data,
    output logic                          ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]      ram_rd_addr,
    input  skt_pkg::entry_t               ram_rd_data
);

    import skt_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t               state_reg, state_next;
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [GRADE_W-1:0]   grade_reg, grade_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [CNT_W-1:0]     mid_reg, mid_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 hit_reg, hit_next;
    logic [GRADE_W-1:0]   pgrade_reg, pgrade_next;
    result_t              res_reg, res_next;

    logic [CNT_W-1:0]     mid;
    logic [CNT_W-1:0]     idx_dec;
    logic [CNT_W-1:0]     idx_inc;
    logic [CNT_W-1:0]     cnt_dec;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 key_lt;
    logic                 key_eq;

    function automatic result_t pack_res(
        input logic [STATUS_W-1:0] st,
        input logic [POS_W-1:0]    pos,
        input logic [KEY_W-1:0]    k,
        input logic [GRADE_W-1:0]  g,
        input logic [COUNT_W-1:0]  c,
        input logic                l
    );
        result_t r;
        r.status   = st;
        r.position = pos;
        r.key      = k;
        r.grade    = g;
        r.count    = c;
        r.last     = l;
        return r;
    endfunction

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec = idx_reg - CNT_W'(1);
    assign idx_inc = idx_reg + CNT_W'(1);
    assign cnt_dec = count_reg - CNT_W'(1);
    assign cnt_inc = count_reg + CNT_W'(1);
    assign key_lt  = ram_rd_data.key < key_reg;
    assign key_eq  = ram_rd_data.key == key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        grade_reg  <= grade_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        pgrade_reg <= pgrade_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (func == FUNC_LIST)
                    begin
                        state_next = (count_reg == '0) ? ST_EMIT : ST_LIST_RD;
                    end
                    else if (func < FUNC_LIST)
                    begin
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_SRCH_RD;
                end
                else if (lo_reg < count_reg)
                begin
                    state_next = ST_PROBE;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_SRCH_RD: state_next = ST_SRCH;
            ST_PROBE:   state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (hit_reg || count_reg == FULL_CNT)
                        begin
                            state_next = ST_EMIT;
                        end
                        else if (count_reg > lo_reg)
                        begin
                            state_next = ST_INS_RD;
                        end
                        else
                        begin
                            state_next = ST_INS_FIN;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (hit_reg && lo_reg < cnt_dec)
                        begin
                            state_next = ST_DEL_RD;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    default: state_next = ST_EMIT;
                endcase
            end
            ST_INS_RD:  state_next = ST_INS_WR;
            ST_INS_WR:  state_next = (idx_dec > lo_reg) ? ST_INS_RD : ST_INS_FIN;
            ST_INS_FIN: state_next = ST_EMIT;
            ST_DEL_RD:  state_next = ST_DEL_WR;
            ST_DEL_WR:  state_next = (idx_inc < count_reg) ? ST_DEL_RD : ST_EMIT;
            ST_LIST_RD: state_next = ST_LIST_LD;
            ST_LIST_LD: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = res_reg.last ? ST_IDLE : ST_LIST_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        func_next   = func_reg;
        key_next    = key_reg;
        grade_next  = grade_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        hit_next    = hit_reg;
        pgrade_next = pgrade_reg;
        res_next    = res_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg[IDX_W-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = mid[IDX_W-1:0];
        req_stall   = (state_reg != ST_IDLE);
        res_valid   = (state_reg == ST_EMIT);
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = func;
                    key_next   = key;
                    grade_next = grade;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    idx_next   = '0;
                    res_next   = pack_res(STAT_EMPTY, '0, '0, '0,
                                          COUNT_W'(count_reg), 1'b1);
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_rd_en = 1'b1;
                    mid_next  = mid;
                end
                else if (lo_reg < count_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = lo_reg[IDX_W-1:0];
                end
                else
                begin
                    hit_next = 1'b0;
                end
            end
            ST_SRCH_RD:
            begin
                if (key_lt)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            ST_PROBE:
            begin
                hit_next    = key_eq;
                pgrade_next = ram_rd_data.grade;
            end
            ST_DECIDE:
            begin
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            res_next = pack_res(STAT_DUP, POS_W'(lo_reg), key_reg,
                                                pgrade_reg, COUNT_W'(count_reg), 1'b1);
                        end
                        else if (count_reg == FULL_CNT)
                        begin
                            res_next = pack_res(STAT_FULL, '0, key_reg, '0,
                                                COUNT_W'(count_reg), 1'b1);
                        end
                        else
                        begin
                            idx_next = count_reg;
                        end
                    end
                    default:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next = pack_res(STAT_EMPTY, '0, key_reg, '0,
                                                COUNT_W'(count_reg), 1'b1);
                        end
                        else if (!hit_reg)
                        begin
                            res_next = pack_res(STAT_NOTFOUND, '0, key_reg, '0,
                                                COUNT_W'(count_reg), 1'b1);
                        end
                        else if (func_reg == FUNC_UPDATE)
                        begin
                            ram_wr_en         = 1'b1;
                            ram_wr_addr       = lo_reg[IDX_W-1:0];
                            ram_wr_data.key   = key_reg;
                            ram_wr_data.grade = grade_reg;
                            res_next = pack_res(STAT_OK, POS_W'(lo_reg), key_reg,
                                                grade_reg, COUNT_W'(count_reg), 1'b1);
                        end
                        else if (func_reg == FUNC_DELETE)
                        begin
                            count_next = cnt_dec;
                            idx_next   = lo_reg;
                            res_next = pack_res(STAT_OK, POS_W'(lo_reg), key_reg,
                                                pgrade_reg, COUNT_W'(cnt_dec), 1'b1);
                        end
                        else
                        begin
                            res_next = pack_res(STAT_OK, POS_W'(lo_reg), key_reg,
                                                pgrade_reg, COUNT_W'(count_reg), 1'b1);
                        end
                    end
                endcase
            end
            ST_INS_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_dec[IDX_W-1:0];
            end
            ST_INS_WR:
            begin
                ram_wr_en = 1'b1;
                idx_next  = idx_dec;
            end
            ST_INS_FIN:
            begin
                ram_wr_en         = 1'b1;
                ram_wr_addr       = lo_reg[IDX_W-1:0];
                ram_wr_data.key   = key_reg;
                ram_wr_data.grade = grade_reg;
                count_next        = cnt_inc;
                res_next = pack_res(STAT_OK, POS_W'(lo_reg), key_reg, grade_reg,
                                    COUNT_W'(cnt_inc), 1'b1);
            end
            ST_DEL_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_inc[IDX_W-1:0];
            end
            ST_DEL_WR:
            begin
                ram_wr_en = 1'b1;
                idx_next  = idx_inc;
            end
            ST_LIST_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_reg[IDX_W-1:0];
            end
            ST_LIST_LD:
            begin
                res_next = pack_res(STAT_OK, POS_W'(idx_reg), ram_rd_data.key,
                                    ram_rd_data.grade, COUNT_W'(count_reg),
                                    idx_inc == count_reg);
                idx_next = idx_inc;
            end
            ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

endmodule

>>> rtl/core/sorted_key_table.sv
// Top level of the sorted key table: entry RAM, sequencer and result register.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------------
//   request  | req_valid, req_stall  | func, key, grade
//   response | rsp_valid, rsp_stall  | status, position, found_key, found_grade, count, last
//
// Search: each halving step over the stored count takes a state that issues the read
// and one that compares, then come a closing compare, a probe read when the position
// lies inside the table, a decision and the emit state. Insert and delete add one RAM
// read and one RAM write per shifted entry. List reads, loads and emits each entry.
// Reset clears the count, the state and the response valid flag; RAM entries stay
// unknown until written.
// The response register lets the block take the next request while a final
// response still waits; rsp_stall holds the walk of a list between entries.
module sorted_key_table #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [skt_pkg::FUNC_W-1:0]    func,
    input  logic [skt_pkg::KEY_W-1:0]     key,
    input  logic [skt_pkg::GRADE_W-1:0]   grade,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [skt_pkg::STATUS_W-1:0]  status,
    output logic [skt_pkg::POS_W-1:0]     position,
    output logic [skt_pkg::KEY_W-1:0]     found_key,
    output logic [skt_pkg::GRADE_W-1:0]   found_grade,
    output logic [skt_pkg::COUNT_W-1:0]   count,
    output logic                          last
);

    import skt_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    entry_t             ram_wr_data;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    entry_t             ram_rd_data;

    logic               res_valid;
    logic               res_ready;
    result_t            res;

    logic               rsp_valid_reg, rsp_valid_next;
    result_t            rsp_reg, rsp_next;

    skt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    skt_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .key         (key),
        .grade       (grade),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_reg.status;
    assign position    = rsp_reg.position;
    assign found_key   = rsp_reg.key;
    assign found_grade = rsp_reg.grade;
    assign count       = rsp_reg.count;
    assign last        = rsp_reg.last;

endmodule

>>> rtl/core/skt_checker.sv
// Port-level checker for the sorted key table, bound to the top level.
module skt_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [skt_pkg::FUNC_W-1:0]    func,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [skt_pkg::STATUS_W-1:0]  status,
    input  logic [skt_pkg::POS_W-1:0]     position,
    input  logic [skt_pkg::KEY_W-1:0]     found_key,
    input  logic [skt_pkg::GRADE_W-1:0]   found_grade,
    input  logic [skt_pkg::COUNT_W-1:0]   count,
    input  logic                          last
);

    import skt_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid &&
            $stable({status, position, found_key, found_grade, count, last}))
        else $error("response changed while stalled");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STAT_OK |-> last)
        else $error("error response without last");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_FULL || status == STAT_NOTFOUND ||
            status == STAT_EMPTY) |-> position == '0 && found_grade == '0)
        else $error("miss response carries position or grade");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && func <= FUNC_LIST |=> req_stall)
        else $error("request side open right after a valid operation");

    a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> req_stall)
        else $error("request side open in the middle of a list");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .func        (func),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .position    (position),
    .found_key   (found_key),
    .found_grade (found_grade),
    .count       (count),
    .last        (last)
);

>>> tb/sorted_key_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_key_table: directed and random operations against a predictor.
module sorted_key_table_tb;
    import skt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;
    localparam logic [KEY_W-1:0] KEY_TOP = KEY_W'(99999999);
    localparam logic [FUNC_W-1:0] FUNC_RSVD_FIRST = FUNC_LIST + 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_LAST = '1;

    class key_table_scoreboard;
        logic [KEY_W-1:0]   keys[TABLE_DEPTH];
        logic [GRADE_W-1:0] grades[TABLE_DEPTH];
        int unsigned        entries;
        result_t            expected_results[$];
        int                 errors;

        function int outstanding();
            return expected_results.size();
        endfunction

        function void add_result(logic [STATUS_W-1:0] st, int unsigned pos,
                                 logic [KEY_W-1:0] k, logic [GRADE_W-1:0] g, bit fin);
            result_t r;
            r.status = st;
            r.position = POS_W'(pos);
            r.key = k;
            r.grade = g;
            r.count = COUNT_W'(entries);
            r.last = fin;
            expected_results.push_back(r);
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                   logic [GRADE_W-1:0] g);
            int unsigned lo, hi, mid, p;
            bit hit;
            logic [GRADE_W-1:0] old_grade;
            if (f > FUNC_LIST)
                return;
            if (f == FUNC_LIST)
            begin
                if (entries == 0)
                    add_result(STAT_EMPTY, 0, '0, '0, 1'b1);
                else
                    for (int unsigned i = 0; i < entries; i++)
                        add_result(STAT_OK, i, keys[i], grades[i], i + 1 == entries);
                return;
            end
            lo = 0;
            hi = entries;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] < k)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            p = lo;
            hit = (p < entries) && (keys[p] == k);
            if (f == FUNC_INSERT)
            begin
                if (hit)
                    add_result(STAT_DUP, p, k, grades[p], 1'b1);
                else if (entries >= TABLE_DEPTH)
                    add_result(STAT_FULL, 0, k, '0, 1'b1);
                else
                begin
                    for (int unsigned i = entries; i > p; i--)
                    begin
                        keys[i] = keys[i - 1];
                        grades[i] = grades[i - 1];
                    end
                    keys[p] = k;
                    grades[p] = g;
                    entries++;
                    add_result(STAT_OK, p, k, g, 1'b1);
                end
            end
            else if (entries == 0)
                add_result(STAT_EMPTY, 0, k, '0, 1'b1);
            else if (!hit)
                add_result(STAT_NOTFOUND, 0, k, '0, 1'b1);
            else if (f == FUNC_UPDATE)
            begin
                grades[p] = g;
                add_result(STAT_OK, p, k, g, 1'b1);
            end
            else if (f == FUNC_DELETE)
            begin
                old_grade = grades[p];
                for (int unsigned i = p; i + 1 < entries; i++)
                begin
                    keys[i] = keys[i + 1];
                    grades[i] = grades[i + 1];
                end
                entries--;
                add_result(STAT_OK, p, k, old_grade, 1'b1);
            end
            else
                add_result(STAT_OK, p, k, grades[p], 1'b1);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_response(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d key %0d", got.status, got.key);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare("status", 32'(want.status), 32'(got.status));
            compare("position", 32'(want.position), 32'(got.position));
            compare("found_key", 32'(want.key), 32'(got.key));
            compare("found_grade", 32'(want.grade), 32'(got.grade));
            compare("count", 32'(want.count), 32'(got.count));
            compare("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    key;
    logic [GRADE_W-1:0]  grade;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    found_key;
    logic [GRADE_W-1:0]  found_grade;
    logic [COUNT_W-1:0]  count;
    logic                last;

    key_table_scoreboard sb = new();
    int      send_idle;
    int      rcv_idle;
    bit      hold_off_req;
    bit      req_taken;
    bit      rsp_taken;
    int      quiet_cycles;
    result_t seen;

    sorted_key_table #(.DEPTH(TABLE_DEPTH)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .func(func),
        .key(key),
        .grade(grade),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .status(status),
        .position(position),
        .found_key(found_key),
        .found_grade(found_grade),
        .count(count),
        .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken = req_valid && !req_stall;
            rsp_taken = rsp_valid && !rsp_stall;
            if (req_taken)
                sb.note_request(func, key, grade);
            if (rsp_taken)
            begin
                seen = {status, position, found_key, found_grade, count, last};
                sb.check_response(seen);
            end
            if (req_taken || rsp_taken)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                rsp_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                             input logic [GRADE_W-1:0] g);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        func <= f;
        key <= k;
        grade <= g;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic pause_until_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    task automatic send_random(input int ins_pct, input int del_pct);
        int r;
        int hit_pct;
        logic [FUNC_W-1:0]  f;
        logic [KEY_W-1:0]   k;
        logic [GRADE_W-1:0] g;
        r = $urandom_range(99);
        if (r < ins_pct)
            f = FUNC_INSERT;
        else if (r < ins_pct + del_pct)
            f = FUNC_DELETE;
        else if (r < 92)
            f = $urandom_range(1) ? FUNC_UPDATE : FUNC_LOOKUP;
        else if (r < 97)
            f = FUNC_LIST;
        else
            f = FUNC_W'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST));
        hit_pct = (f == FUNC_INSERT) ? 15 : 80;
        r = $urandom_range(99);
        if (sb.entries != 0 && r < hit_pct)
            k = sb.keys[$urandom_range(sb.entries - 1)];
        else if (r < hit_pct + 10)
        begin
            case ($urandom_range(2))
                0: k = '0;
                1: k = KEY_MAX;
                default: k = KEY_TOP;
            endcase
        end
        else if (r < hit_pct + 20)
            k = KEY_W'($urandom);
        else
            k = KEY_W'($urandom_range(KEY_TOP));
        if ($urandom_range(9) == 0)
            g = GRADE_W'($urandom_range(101, 127));
        else
            g = GRADE_W'($urandom_range(100));
        send_item(f, k, g);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        func = FUNC_INSERT;
        key = '0;
        grade = '0;
        send_idle = 31;
        rcv_idle = 76;
        hold_off_req = 1'b0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FUNC_LIST, '0, '0);
        send_item(FUNC_LOOKUP, KEY_W'(5), '0);
        send_item(FUNC_UPDATE, KEY_W'(5), GRADE_W'(9));
        send_item(FUNC_DELETE, KEY_W'(5), '0);
        send_item(FUNC_INSERT, KEY_W'(1000), GRADE_W'(50));
        send_item(FUNC_INSERT, '0, '0);
        send_item(FUNC_INSERT, KEY_MAX, '1);
        send_item(FUNC_INSERT, KEY_TOP, GRADE_W'(100));
        send_item(FUNC_INSERT, KEY_W'(500), GRADE_W'(7));
        send_item(FUNC_INSERT, KEY_W'(1000), GRADE_W'(1));
        send_item(FUNC_LOOKUP, '0, '0);
        send_item(FUNC_LOOKUP, KEY_MAX, '0);
        send_item(FUNC_LOOKUP, KEY_W'(501), '0);
        send_item(FUNC_UPDATE, KEY_W'(500), GRADE_W'(100));
        send_item(FUNC_UPDATE, KEY_W'(777), GRADE_W'(3));
        send_item(FUNC_DELETE, KEY_W'(1000), '0);
        send_item(FUNC_DELETE, KEY_W'(1000), '0);
        send_item(FUNC_RSVD_FIRST, KEY_W'(500), GRADE_W'(5));
        send_item(FUNC_RSVD_LAST, KEY_MAX, '1);
        send_item(FUNC_LIST, '0, '0);
        send_item(FUNC_DELETE, '0, '0);
        send_item(FUNC_DELETE, KEY_MAX, '0);
        send_item(FUNC_LIST, '0, '0);

        // fill the table until inserts are rejected as full
        repeat (140) send_random(75, 5);
        pause_until_drained();

        // drain the table toward empty
        send_idle = 76;
        rcv_idle = 31;
        repeat (140) send_random(5, 75);
        pause_until_drained();

        send_idle = 0;
        rcv_idle = 0;
        repeat (50) send_random(30, 25);
        pause_until_drained();
        hold_off_req = 1'b1;
        repeat (100) send_random(30, 25);

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
